FILE: rtl/calibration_table_interpolator_core_defines.svh
// Assertion macros shared by the checker of the calibration table interpolator.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef CALIBRATION_TABLE_INTERPOLATOR_CORE_DEFINES_SVH
`define CALIBRATION_TABLE_INTERPOLATOR_CORE_DEFINES_SVH

// Clocked assertion, masked while reset is held
`define CTIC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ctic assertion failed");

// Same, written as antecedent and consequent
`define CTIC_ASSERT_IMP(label, ante, cons) \
  `CTIC_ASSERT(label, (ante) |-> (cons))

`endif

FILE: rtl/ctic_pkg.sv
// Package of the calibration table interpolator: codes, point type, cell commands.
// No dependencies.
package ctic_pkg;

  localparam int MAX_POINTS_DEF = 32;
  localparam logic [11:0] POS_LIMIT = 12'd4095;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  // divider: 32-bit signed numerator, magnitude of 31 bits
  localparam int NUM_W     = 32;
  localparam int DIV_STEPS = 31;

  typedef struct packed {
    logic [11:0]        pos;
    logic signed [15:0] focal;
  } point_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROT,
    CELL_INS,
    CELL_UPD
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    point_t   pt;
  } cell_cmd_t;

endpackage

FILE: rtl/ctic_req_if.sv
// Request channel of the calibration table interpolator.
// No dependencies.
interface ctic_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [15:0]        position;
  logic signed [15:0] focal_in;

  modport source (output valid, req_type, position, focal_in, input ready);
  modport sink   (input valid, req_type, position, focal_in, output ready);
endinterface

FILE: rtl/ctic_rsp_if.sv
// Response channel of the calibration table interpolator.
// No dependencies.
interface ctic_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [15:0] focal_out;
  logic [5:0]         point_count;

  modport source (output valid, status, focal_out, point_count, input ready);
  modport sink   (input valid, status, focal_out, point_count, output ready);
endinterface

FILE: rtl/calibration_table_interpolator_core.sv
// Calibration table interpolator: a rotating row of point cells plus control.
// Depends on ctic_pkg, ctic_req_if, ctic_rsp_if, ctic_cell, ctic_div.
//
// Use: one request beat on req_i (insert/update, lookup, clear) gives one
// response beat on rsp_o with status, focal value and the point count.
// Points sit sorted in a row of MAX_POINTS cells. Insert and lookup scan the
// row by rotating it one cell a cycle through cell 0, a full turn of
// MAX_POINTS cells, so the row ends in its original order. An insert then
// has an apply step in which the cells above the slot shift up in parallel.
// Path from accept to response valid:
//   clear, out-of-range, empty lookup, unused type: straight to the output;
//   insert: row scan, then the apply step;
//   lookup on a match or at the table edge: row scan, then the result step;
//   interpolating lookup: row scan, the differences, both products in one
//   step, the divider start on the summed numerator, then 31 divide steps.
// One request is worked on at a time; req_i.ready is high only when idle.
// A finished response waits in the output register while the next request
// is accepted; if the receiver stalls, the following result waits in turn.
// Reset empties the table at once; cell contents are not cleared.
module calibration_table_interpolator_core
  import ctic_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ctic_req_if.sink    req_i,
  ctic_rsp_if.source  rsp_o
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] CntMax = CNT_W'(MAX_POINTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_LKP   = 3'd3;
  localparam logic [2:0] S_MUL1  = 3'd4;
  localparam logic [2:0] S_MUL2  = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   k_q;
  logic [1:0]         req_q;
  logic [11:0]        x_q;
  logic signed [15:0] fin_q;
  logic               found_q, eq_q;
  logic [IDX_W-1:0]   hi_q;
  point_t             prev_q, p0_q, p1_q;
  logic signed [15:0] flast_q;
  logic [1:0]         res_stat_q, res_stat_d;
  logic signed [15:0] res_foc_q, res_foc_d;
  logic signed [NUM_W-1:0] prod0_q, prod1_q, num_sum;
  logic [11:0]        d_q, t_q;
  logic               div_start;
  logic               div_done;
  logic signed [15:0] div_quot;
  logic               out_valid_q;
  logic [1:0]         out_stat_q;
  logic signed [15:0] out_foc_q;
  logic [5:0]         out_cnt_q;

  cell_cmd_t          cmd;
  logic [IDX_W-1:0]   slot;
  point_t             cell_pt [MAX_POINTS];
  point_t             head;
  logic               in_acc, out_free, pos_bad;

  assign in_acc   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign pos_bad  = (req_i.position > {4'd0, POS_LIMIT});
  assign head     = cell_pt[0];
  assign req_i.ready = (state_q == S_IDLE);

  // row of cells; rotation feeds cell 0 back into the top
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    ctic_cell #(.CELL_IDX(i), .IDX_W(IDX_W)) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .slot_i (slot),
      .nxt_i  (cell_pt[(i + 1) % MAX_POINTS]),
      .prv_i  ((i == 0) ? cmd.pt : cell_pt[(i + MAX_POINTS - 1) % MAX_POINTS]),
      .pt_o   (cell_pt[i])
    );
  end

  // cell command and slot
  always_comb begin
    cmd.op       = CELL_HOLD;
    cmd.pt.pos   = x_q;
    cmd.pt.focal = fin_q;
    slot         = found_q ? hi_q : IDX_W'(count_q);
    if (state_q == S_SCAN) begin
      cmd.op = CELL_ROT;
    end else if (state_q == S_APPLY) begin
      if (found_q && eq_q) cmd.op = CELL_UPD;
      else if (count_q != CntMax) cmd.op = CELL_INS;
    end
  end

  // control
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    res_stat_d = res_stat_q;
    res_foc_d  = res_foc_q;
    div_start  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_stat_d = STAT_OK;
          res_foc_d  = '0;
          state_d    = S_FIN;
          case (req_i.req_type)
            REQ_INSERT: begin
              if (pos_bad) res_stat_d = STAT_RANGE;
              else state_d = S_SCAN;
            end
            REQ_LOOKUP: begin
              if (pos_bad) res_stat_d = STAT_RANGE;
              else if (count_q == '0) res_stat_d = STAT_EMPTY;
              else state_d = S_SCAN;
            end
            REQ_CLEAR: count_d = '0;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (k_q == CNT_W'(MAX_POINTS - 1)) begin
          state_d = (req_q == REQ_INSERT) ? S_APPLY : S_LKP;
        end
      end
      S_APPLY: begin
        state_d = S_FIN;
        if (!(found_q && eq_q)) begin
          if (count_q == CntMax) res_stat_d = STAT_FULL;
          else count_d = count_q + 1'b1;
        end
      end
      S_LKP: begin
        state_d = S_FIN;
        if (!found_q) res_foc_d = flast_q;
        else if (eq_q || hi_q == '0) res_foc_d = p1_q.focal;
        else state_d = S_MUL1;
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          res_foc_d = div_quot;
          state_d   = S_FIN;
        end
      end
      S_FIN: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == S_FIN && out_free) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  // scan bookkeeping and arithmetic
  always_ff @(posedge clk_i) begin
    res_stat_q <= res_stat_d;
    res_foc_q  <= res_foc_d;
    if (in_acc) begin
      req_q   <= req_i.req_type;
      x_q     <= req_i.position[11:0];
      fin_q   <= req_i.focal_in;
      k_q     <= '0;
      found_q <= 1'b0;
      eq_q    <= 1'b0;
    end
    if (state_q == S_SCAN) begin
      k_q    <= k_q + 1'b1;
      prev_q <= head;
      if (!found_q && k_q < count_q && head.pos >= x_q) begin
        found_q <= 1'b1;
        hi_q    <= k_q[IDX_W-1:0];
        eq_q    <= (head.pos == x_q);
        p1_q    <= head;
        p0_q    <= prev_q;
      end
      if (k_q == count_q - 1'b1) flast_q <= head.focal;
    end
    if (state_q == S_LKP) begin
      d_q <= p1_q.pos - p0_q.pos;
      t_q <= x_q - p0_q.pos;
    end
    // both products together; their sum feeds the divider start
    if (state_q == S_MUL1) begin
      prod0_q <= NUM_W'(p0_q.focal * $signed({1'b0, d_q}));
      prod1_q <= NUM_W'(($signed({p1_q.focal[15], p1_q.focal})
                         - $signed({p0_q.focal[15], p0_q.focal}))
                        * $signed({1'b0, t_q}));
    end
    if (state_q == S_FIN && out_free) begin
      out_stat_q <= res_stat_q;
      out_foc_q  <= res_foc_q;
      out_cnt_q  <= 6'(count_q);
    end
  end

  assign num_sum = prod0_q + prod1_q;

  ctic_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_sum),
    .den_i   (d_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_stat_q;
  assign rsp_o.focal_out   = out_foc_q;
  assign rsp_o.point_count = out_cnt_q;

endmodule

FILE: rtl/ctic_cell.sv
// One table cell: holds a point, rotates, shifts up on insert or takes an update.
// Depends on ctic_pkg.
module ctic_cell
  import ctic_pkg::*;
#(
  parameter int CELL_IDX = 0,
  parameter int IDX_W    = 5
) (
  input  logic             clk_i,
  input  cell_cmd_t        cmd_i,
  input  logic [IDX_W-1:0] slot_i,
  input  point_t           nxt_i,
  input  point_t           prv_i,
  output point_t           pt_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  point_t pt_q, pt_d;

  // next content of this cell
  always_comb begin
    pt_d = pt_q;
    case (cmd_i.op)
      CELL_ROT: pt_d = nxt_i;
      CELL_INS: begin
        if (MyIdx == slot_i) pt_d = cmd_i.pt;
        else if (MyIdx > slot_i) pt_d = prv_i;
      end
      CELL_UPD: if (MyIdx == slot_i) pt_d.focal = cmd_i.pt.focal;
      default: pt_d = pt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    pt_q <= pt_d;
  end

  assign pt_o = pt_q;

endmodule

FILE: rtl/ctic_div.sv
// Restoring signed divider, one quotient bit a cycle, truncates toward zero.
// Depends on ctic_pkg.
module ctic_div
  import ctic_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [11:0]             den_i,
  output logic                    done_o,
  output logic signed [15:0]      quot_o
);

  localparam int CntW = $clog2(DIV_STEPS + 1);

  logic                  busy_q, done_q;
  logic [CntW-1:0]       cnt_q;
  logic                  neg_q;
  logic [DIV_STEPS-1:0]  mag_q;
  logic [12:0]           rem_q;
  logic [11:0]           den_q;
  logic signed [15:0]    quot_q;
  logic [12:0]           rem_sh;
  logic                  qbit;
  logic [12:0]           rem_nx;
  logic [DIV_STEPS-1:0]  mag_nx;
  logic [NUM_W-1:0]      num_abs;

  // one step: shift in next bit, subtract when it fits
  always_comb begin
    rem_sh  = {rem_q[11:0], mag_q[DIV_STEPS-1]};
    qbit    = (rem_sh >= {1'b0, den_q});
    rem_nx  = qbit ? rem_sh - {1'b0, den_q} : rem_sh;
    mag_nx  = {mag_q[DIV_STEPS-2:0], qbit};
    num_abs = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NUM_W-1];
      mag_q <= num_abs[DIV_STEPS-1:0];
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_nx;
      mag_q <= mag_nx;
      if (cnt_q == CntW'(1)) begin
        quot_q <= neg_q ? -$signed(mag_nx[15:0]) : $signed(mag_nx[15:0]);
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: rtl/ctic_checker.sv
// Port-level checks of the calibration table interpolator, bound to the top.
// Depends on ctic_pkg and calibration_table_interpolator_core_defines.svh.
`include "calibration_table_interpolator_core_defines.svh"

module ctic_checker
  import ctic_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic [1:0]         status_i,
  input logic signed [15:0] focal_out_i,
  input logic [5:0]         point_count_i
);

  // count never exceeds the table size
  `CTIC_ASSERT_IMP(a_count_max, rsp_valid_i, 9'(point_count_i) <= 9'(MAX_POINTS))

  // failed requests carry a zero focal value
  `CTIC_ASSERT_IMP(a_err_zero, rsp_valid_i && status_i != STAT_OK, focal_out_i == 16'sd0)

  // one request at a time: busy right after a beat is taken
  `CTIC_ASSERT_IMP(a_busy, req_valid_i && req_ready_i, ##1 !req_ready_i)

  // stalled response holds its payload
  `CTIC_ASSERT_IMP(a_hold, rsp_valid_i && !rsp_ready_i,
    ##1 (rsp_valid_i && $stable(status_i) && $stable(focal_out_i) && $stable(point_count_i)))

endmodule

bind calibration_table_interpolator_core ctic_checker #(.MAX_POINTS(MAX_POINTS)) u_ctic_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .focal_out_i   (rsp_o.focal_out),
  .point_count_i (rsp_o.point_count)
);
